@@ rtl/assert_macros.svh @@
// Assertion macros shared by the limb ALU RTL; clk and rst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, quiet while reset is held
`define FPLA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication
`define FPLA_ASSERT_IMPLY(label, ante, cons, msg) \
    `FPLA_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define FPLA_ASSERT_NEXT(label, ante, cons, msg) \
    `FPLA_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/fpla_pkg.sv @@
// Shared types, widths and helpers for the fixed-point limb ALU.
`timescale 1ns / 1ps

package fpla_pkg;

    // Number format: LIMBS bytes, byte 0 is the signed integer part
    localparam int LIMB_W    = 8;
    localparam int LIMBS     = 8;
    localparam int NUM_W     = LIMB_W * LIMBS;
    localparam int WORD_W    = 64;
    // Magnitude with one guard byte below it, and its product with one limb
    localparam int ROW_W     = NUM_W + LIMB_W;
    localparam int PROD_W    = ROW_W + LIMB_W;

    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_NEG = 2'd1,
        OP_MUL = 2'd2
    } opcode_t;

    // Control that travels alongside each word through the pipeline
    typedef struct packed {
        logic    valid;
        opcode_t op;
        logic    flip;      // operand signs differ: negate the product
    } ctl_t;

    // Two's-complement negation, wrapping
    function automatic num_t neg_num(input num_t x);
        return num_t'(~x + num_t'(1));
    endfunction

endpackage

@@ rtl/fpla_in_if.sv @@
// Operand channel: opcode and two Q-format operands.
`timescale 1ns / 1ps

interface fpla_in_if import fpla_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);

endinterface

@@ rtl/fpla_out_if.sv @@
// Result channel: one Q-format result per word.
`timescale 1ns / 1ps

interface fpla_out_if import fpla_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] result_value;

    modport source (output valid, output result_value, input ready);
    modport sink   (input valid, input result_value, output ready);

endinterface

@@ rtl/fixed_point_limb_alu_core.sv @@
// Fixed-point limb ALU: add, negate, multiply on LIMBS-byte two's-complement numbers.
// A taken word passes through the input, operand, product, partial-sum and result
//   registers before its result is shown.
// Throughput: one word per cycle; the five stages move together and hold only
//   while a shown result is not taken.
// Reset (rst_n, asynchronous, active low) empties every stage; no other state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_point_limb_alu_core import fpla_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    fpla_in_if.sink    cmd,
    fpla_out_if.source res
);

    logic             adv;
    ctl_t             s1_ctl_reg, s1_ctl_next;
    num_t             s1_a_reg;
    num_t             s1_b_reg;

    ctl_t             s2_ctl;
    num_t             s2_mag_a;
    num_t             s2_mag_b;
    num_t             s2_alt;
    ctl_t             s3_ctl;
    num_t [LIMBS-1:0] s3_terms;
    num_t             s3_alt;
    logic             res_valid;
    word_t            res_value;

    // Whole pipeline moves unless the result register holds an untaken word
    assign adv       = !res_valid || res.ready;
    assign cmd.ready = adv;

    // Input register
    always_comb
    begin
        s1_ctl_next       = '0;
        s1_ctl_next.valid = cmd.valid;
        s1_ctl_next.op    = opcode_t'(cmd.opcode);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_ctl_reg <= '0;
        else if (adv)
            s1_ctl_reg <= s1_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg <= cmd.operand_a[NUM_W-1:0];
            s1_b_reg <= cmd.operand_b[NUM_W-1:0];
        end
    end

    fpla_prep u_prep (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .up_ctl (s1_ctl_reg),
        .a      (s1_a_reg),
        .b      (s1_b_reg),
        .ctl    (s2_ctl),
        .mag_a  (s2_mag_a),
        .mag_b  (s2_mag_b),
        .alt    (s2_alt)
    );

    fpla_rows u_rows (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .up_ctl (s2_ctl),
        .mag_a  (s2_mag_a),
        .mag_b  (s2_mag_b),
        .up_alt (s2_alt),
        .ctl    (s3_ctl),
        .terms  (s3_terms),
        .alt    (s3_alt)
    );

    fpla_fold u_fold (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .up_ctl (s3_ctl),
        .terms  (s3_terms),
        .up_alt (s3_alt),
        .valid  (res_valid),
        .value  (res_value)
    );

    assign res.valid        = res_valid;
    assign res.result_value = res_value;

    // A stalled result must also stall the operand side
    `FPLA_ASSERT_IMPLY(a_stall_blocks_input, res.valid && !res.ready, !cmd.ready,
        "operand word taken while result is stalled")

endmodule

@@ rtl/fpla_prep.sv @@
// Operand stage: magnitudes and sign for multiply, add and negate results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpla_prep import fpla_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  ctl_t up_ctl,
    input  num_t a,
    input  num_t b,
    output ctl_t ctl,
    output num_t mag_a,
    output num_t mag_b,
    output num_t alt
);

    ctl_t ctl_reg, ctl_next;
    num_t mag_a_reg, mag_a_next;
    num_t mag_b_reg, mag_b_next;
    num_t alt_reg, alt_next;

    // Magnitudes (most negative value stays as is), sign difference, add/negate
    always_comb
    begin
        mag_a_next = a[NUM_W-1] ? neg_num(a) : a;
        mag_b_next = b[NUM_W-1] ? neg_num(b) : b;
        ctl_next       = up_ctl;
        ctl_next.flip  = a[NUM_W-1] ^ b[NUM_W-1];
        if (up_ctl.op == OP_NEG)
            alt_next = neg_num(a);
        else
            alt_next = num_t'(a + b);
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (adv)
            ctl_reg <= ctl_next;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            alt_reg   <= alt_next;
        end
    end

    assign ctl   = ctl_reg;
    assign mag_a = mag_a_reg;
    assign mag_b = mag_b_reg;
    assign alt   = alt_reg;

    // Only the most negative value keeps its top bit after taking the magnitude
    `FPLA_ASSERT_IMPLY(a_mag_top_bit, ctl_reg.valid && mag_a_reg[NUM_W-1],
        mag_a_reg[NUM_W-2:0] == '0, "magnitude of a has top bit set with other bits")

endmodule

@@ rtl/fpla_rows.sv @@
// Product stage: one truncated row product per limb of the magnitude of b.
`timescale 1ns / 1ps

module fpla_rows import fpla_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  ctl_t              up_ctl,
    input  num_t              mag_a,
    input  num_t              mag_b,
    input  num_t              up_alt,
    output ctl_t              ctl,
    output num_t [LIMBS-1:0]  terms,
    output num_t              alt
);

    ctl_t             ctl_reg;
    num_t [LIMBS-1:0] terms_reg, terms_next;
    num_t             alt_reg;

    logic [ROW_W-1:0]  row_src;
    logic [ROW_W-1:0]  shifted;
    logic [LIMB_W-1:0] b_limb;
    logic [PROD_W-1:0] prod;

    // Row j: limb j of b times the top limbs of a that reach the guard byte;
    // the guard byte is dropped and the integer part wraps
    always_comb
    begin
        row_src = {mag_a, {LIMB_W{1'b0}}};
        shifted = '0;
        b_limb  = '0;
        prod    = '0;
        for (int j = 0; j < LIMBS; j++)
        begin
            b_limb        = mag_b[NUM_W-1-LIMB_W*j -: LIMB_W];
            shifted       = row_src >> (LIMB_W * j);
            prod          = PROD_W'(shifted) * PROD_W'(b_limb);
            terms_next[j] = prod[LIMB_W +: NUM_W];
        end
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (adv)
            ctl_reg <= up_ctl;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            terms_reg <= terms_next;
            alt_reg   <= up_alt;
        end
    end

    assign ctl   = ctl_reg;
    assign terms = terms_reg;
    assign alt   = alt_reg;

endmodule

@@ rtl/fpla_fold.sv @@
// Sum of row products, sign fix-up, opcode select and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpla_fold import fpla_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  ctl_t             up_ctl,
    input  num_t [LIMBS-1:0] terms,
    input  num_t             up_alt,
    output logic             valid,
    output word_t            value
);

    ctl_t  ctl_reg;
    num_t  even_reg, even_next;
    num_t  odd_reg, odd_next;
    num_t  alt_reg;
    logic  valid_reg;
    word_t value_reg, value_next;

    num_t  prod;
    num_t  mul_res;
    num_t  res_num;

    // First half of the adder tree: even and odd rows apart
    always_comb
    begin
        even_next = '0;
        odd_next  = '0;
        for (int j = 0; j < LIMBS; j++)
        begin
            if ((j % 2) == 0)
                even_next = num_t'(even_next + terms[j]);
            else
                odd_next = num_t'(odd_next + terms[j]);
        end
    end

    // Final add, sign of product, opcode select, sign extension
    always_comb
    begin
        prod    = num_t'(even_reg + odd_reg);
        mul_res = ctl_reg.flip ? neg_num(prod) : prod;
        case (ctl_reg.op)
            OP_ADD, OP_NEG: res_num = alt_reg;
            OP_MUL:         res_num = mul_res;
            default:        res_num = '0;
        endcase
        value_next = WORD_W'(signed'(res_num));
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl_reg   <= up_ctl;
            valid_reg <= ctl_reg.valid;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            even_reg  <= even_next;
            odd_reg   <= odd_next;
            alt_reg   <= up_alt;
            value_reg <= value_next;
        end
    end

    assign valid = valid_reg;
    assign value = value_reg;

    // The spare opcode gives zero
    `FPLA_ASSERT_NEXT(a_spare_op_zero,
        adv && ctl_reg.valid && ctl_reg.op != OP_ADD && ctl_reg.op != OP_NEG
            && ctl_reg.op != OP_MUL,
        value_reg == '0, "spare opcode did not give zero")

    // A word leaving the sum stage shows up as a valid result
    `FPLA_ASSERT_NEXT(a_sum_to_result, adv && ctl_reg.valid, valid_reg,
        "word lost between sum stage and result register")

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for fixed_point_limb_alu_core: directed and random words, golden model.
`timescale 1ns / 1ps

module testbench;
    import fpla_pkg::*;

    // Opcode value with no operation behind it; the core must return zero
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Handy Q-format values
    localparam word_t Q_ZERO    = 64'h0000_0000_0000_0000;
    localparam word_t Q_ULP     = 64'h0000_0000_0000_0001;
    localparam word_t Q_ONE     = 64'h0100_0000_0000_0000;
    localparam word_t Q_NEG_ONE = 64'hff00_0000_0000_0000;
    localparam word_t Q_MAX     = 64'h7fff_ffff_ffff_ffff;
    localparam word_t Q_MIN     = 64'h8000_0000_0000_0000;
    localparam word_t Q_ALL_SET = 64'hffff_ffff_ffff_ffff;
    localparam word_t Q_FRAC    = 64'h00ff_ffff_ffff_ffff;

    localparam int RANDOM_WORDS = 1200;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 100000;

    typedef struct packed {
        logic [1:0] op;
        word_t      a;
        word_t      b;
    } alu_word_t;

    logic clk = 1'b0;
    logic rst_n;

    fpla_in_if  cmd_ch ();
    fpla_out_if res_ch ();

    fixed_point_limb_alu_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    alu_word_t words_pending[$];
    word_t     results_due[$];
    alu_word_t next_word;

    logic cmd_fire = 1'b0;
    int   words_planned;
    int   words_taken;
    int   results_checked;
    int   mismatches;
    int   cycle_count;
    int   hold_left;
    logic hold_done;
    int   op_count[4];

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Golden model: signed magnitude multiply, one row per byte of b with a guard byte
    function automatic word_t q_product(input num_t x, input num_t y);
        logic [LIMB_W-1:0] mag_a [LIMBS+1];
        logic [LIMB_W-1:0] mag_b [LIMBS];
        logic [LIMB_W-1:0] acc [LIMBS];
        num_t        xm;
        num_t        ym;
        num_t        packed_res;
        int unsigned v;
        int unsigned carry;
        int unsigned guard;
        int          row;
        int          col;
        int          k;
        int          pos;
        xm = x[NUM_W-1] ? num_t'(num_t'(0) - x) : x;
        ym = y[NUM_W-1] ? num_t'(num_t'(0) - y) : y;
        for (k = 0; k < LIMBS; k++)
        begin
            mag_a[k] = xm[NUM_W-1-LIMB_W*k -: LIMB_W];
            mag_b[k] = ym[NUM_W-1-LIMB_W*k -: LIMB_W];
            acc[k]   = '0;
        end
        mag_a[LIMBS] = '0;
        for (row = LIMBS - 1; row >= 0; row--)
        begin
            guard = 0;
            carry = 0;
            for (col = LIMBS - row; col >= 0; col--)
            begin
                pos = row + col;
                v = mag_b[row] * mag_a[col] + carry;
                if (pos < LIMBS)
                begin
                    v = v + acc[pos];
                    acc[pos] = LIMB_W'(v);
                end
                else
                begin
                    v = v + guard;
                    guard = v & 32'hff;
                end
                carry = v >> LIMB_W;
            end
            // ripple what is left of the row carry towards the integer byte
            for (k = row - 1; k >= 0 && carry != 0; k--)
            begin
                v = acc[k] + carry;
                acc[k] = LIMB_W'(v);
                carry = v >> LIMB_W;
            end
        end
        for (k = 0; k < LIMBS; k++)
            packed_res[NUM_W-1-LIMB_W*k -: LIMB_W] = acc[k];
        if (x[NUM_W-1] != y[NUM_W-1])
            packed_res = num_t'(num_t'(0) - packed_res);
        return word_t'($signed(packed_res));
    endfunction

    function automatic word_t alu_expected(input logic [1:0] op, input word_t a, input word_t b);
        num_t x;
        num_t y;
        x = a[NUM_W-1:0];
        y = b[NUM_W-1:0];
        case (op)
            OP_ADD:  return word_t'($signed(num_t'(x + y)));
            OP_NEG:  return word_t'($signed(num_t'(num_t'(0) - x)));
            OP_MUL:  return q_product(x, y);
            default: return '0;
        endcase
    endfunction

    // Random operand drawn from a mix of shapes: full range, small, corner, integral, near one
    function automatic word_t pick_operand();
        word_t corners [8];
        corners = '{Q_ZERO, Q_ULP, Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN, Q_ALL_SET, Q_FRAC};
        case ($urandom_range(0, 5))
            0: return word_t'($signed({$urandom(), $urandom()}) >>> $urandom_range(8, 60));
            1: return corners[$urandom_range(0, 7)];
            2: return {8'($urandom()), 56'h0};
            3: return Q_ONE + word_t'($signed(32'($urandom())) >>> $urandom_range(0, 24));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [1:0] pick_opcode();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 6)
            return OP_ADD;
        else if (pick < 10)
            return OP_NEG;
        else if (pick < 19)
            return OP_MUL;
        return OP_SPARE;
    endfunction

    task automatic queue_word(input logic [1:0] op, input word_t a, input word_t b);
        alu_word_t w;
        w.op = op;
        w.a  = a;
        w.b  = b;
        words_pending.insert(words_pending.size(), w);
    endtask

    task automatic next_result_check(input word_t want, input word_t got);
        results_checked = results_checked + 1;
        if (got !== want)
        begin
            $error("result_value: expected %h, got %h", want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Input side: feed words from the pending queue, idling per phase
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_ch.valid || cmd_fire)
            begin
                if (words_pending.size() != 0 &&
                    (hold_left != 0 || $urandom_range(0, 99) >=
                     (words_taken < words_planned / 3 ? 21 :
                      words_taken < 2 * words_planned / 3 ? 49 : 0)))
                begin
                    next_word = words_pending.pop_front();
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.opcode    <= next_word.op;
                    cmd_ch.operand_a <= next_word.a;
                    cmd_ch.operand_b <= next_word.b;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off to fill the pipe
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (!hold_done && words_taken >= HOLD_AT)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
            res_ch.ready <= $urandom_range(0, 99) >=
                            (words_taken < words_planned / 3 ? 49 :
                             words_taken < 2 * words_planned / 3 ? 21 : 0);
    end

    // Accepted operand words: predict the result
    always @(posedge clk)
    begin
        cmd_fire <= cmd_ch.valid && cmd_ch.ready;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            results_due.insert(results_due.size(),
                               alu_expected(cmd_ch.opcode, cmd_ch.operand_a,
                                            cmd_ch.operand_b));
            op_count[cmd_ch.opcode] = op_count[cmd_ch.opcode] + 1;
            words_taken = words_taken + 1;
        end
    end

    // Accepted result words: compare with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result_value: expected none, got %h", res_ch.result_value);
                mismatches = mismatches + 1;
            end
            else
            begin
                next_result_check(results_due.pop_front(), res_ch.result_value);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding", cycle_count,
                     results_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.opcode    = OP_ADD;
        cmd_ch.operand_a = '0;
        cmd_ch.operand_b = '0;
        res_ch.ready     = 1'b0;
        words_taken      = 0;
        results_checked  = 0;
        mismatches       = 0;
        cycle_count      = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        op_count         = '{0, 0, 0, 0};

        // Directed: wrap, sign corners, guard truncation and the unused opcode
        queue_word(OP_ADD, Q_MAX, Q_ULP);
        queue_word(OP_ADD, Q_MIN, Q_MIN);
        queue_word(OP_ADD, Q_ALL_SET, Q_ULP);
        queue_word(OP_ADD, Q_ONE, Q_NEG_ONE);
        queue_word(OP_ADD, Q_MAX, Q_MAX);
        queue_word(OP_NEG, Q_MIN, Q_ALL_SET);
        queue_word(OP_NEG, Q_ZERO, Q_MAX);
        queue_word(OP_NEG, Q_MAX, Q_ZERO);
        queue_word(OP_NEG, Q_ULP, {$urandom(), $urandom()});
        queue_word(OP_MUL, Q_MIN, Q_MIN);
        queue_word(OP_MUL, Q_MIN, Q_ONE);
        queue_word(OP_MUL, Q_MAX, Q_MAX);
        queue_word(OP_MUL, Q_MAX, Q_MIN);
        queue_word(OP_MUL, Q_NEG_ONE, Q_NEG_ONE);
        queue_word(OP_MUL, Q_ULP, Q_ULP);
        queue_word(OP_MUL, Q_ALL_SET, Q_ALL_SET);
        queue_word(OP_MUL, Q_FRAC, Q_FRAC);
        queue_word(OP_MUL, Q_ONE, {$urandom(), $urandom()});
        queue_word(OP_MUL, {$urandom(), $urandom()}, Q_NEG_ONE);
        queue_word(OP_MUL, Q_ZERO, Q_MIN);
        queue_word(OP_SPARE, Q_MAX, Q_MIN);
        queue_word(OP_SPARE, {$urandom(), $urandom()}, {$urandom(), $urandom()});

        // Random words
        repeat (RANDOM_WORDS)
            queue_word(pick_opcode(), pick_operand(), pick_operand());
        words_planned = words_pending.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: all words taken, all results back, then wait out DRAIN_CYCLES
        while (words_pending.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words: %0d add, %0d negate, %0d multiply, %0d unused opcode",
                 words_taken, op_count[OP_ADD], op_count[OP_NEG], op_count[OP_MUL],
                 op_count[OP_SPARE]);
        $display("Checked %0d results under three idling phases and a long stall: %0d bad",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
